@@ sv/assert_macros.svh @@
// Assertion macros shared by the meter report decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

@@ sv/mrd_pkg.sv @@
// Package with types, constants and helpers of the meter report decoder
`default_nettype none

package mrd_pkg;

	localparam logic [4:0] HEADER_LEN     = 5'd4;
	localparam logic [4:0] DELTA_LEN      = 5'd2;
	localparam logic [2:0] SIZE_CODE_WIDE = 3'd4;
	localparam logic [3:0] POS_MAX        = 4'd15;

	localparam logic [7:0] CLASS_ID_RESET  = 8'd50;
	localparam logic [7:0] REPORT_ID_RESET = 8'd2;

	typedef enum logic [7:0] {
		CFG_CLASS_ID  = 8'd0,
		CFG_REPORT_ID = 8'd1
	} cfg_index_t;

	typedef struct packed {
		logic              ok;
		logic [4:0]        meter_type;
		logic [1:0]        rate_type;
		logic [2:0]        scale;
		logic [2:0]        precision;
		logic [2:0]        value_bytes;
		logic signed [31:0] reading;
		logic [15:0]       delta_time;
		logic              has_previous;
		logic signed [31:0] previous_reading;
	} result_t;

	function automatic logic size_ok(input logic [2:0] s);
		return (s == 3'd1) || (s == 3'd2) || (s == SIZE_CODE_WIDE);
	endfunction

	function automatic logic [31:0] sign_extend(input logic [31:0] raw, input logic [2:0] s);
		logic [31:0] r;
		case (s)
			3'd1:    r = {{24{raw[7]}}, raw[7:0]};
			3'd2:    r = {{16{raw[15]}}, raw[15:0]};
			default: r = raw;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/mrd_in_reg.sv @@
// Input register stage of the meter report decoder
`default_nettype none

module mrd_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] payload_byte,
	input  wire logic       last_byte,
	input  wire logic       drain,
	output logic            valid_s1,
	output logic [7:0]      byte_s1,
	output logic            last_s1
);

	logic load;

	assign in_stall = valid_s1 && !drain;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= payload_byte;
			last_s1 <= last_byte;
		end
	end

endmodule

`default_nettype wire

@@ sv/mrd_core.sv @@
// Payload state and result logic of the meter report decoder
`default_nettype none

module mrd_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] byte_in,
	input  wire logic       last_in,
	input  wire logic [7:0] class_id,
	input  wire logic [7:0] report_id,
	output mrd_pkg::result_t res
);

	logic [3:0]  pos_q;
	logic        hb_q;
	logic [7:0]  props_q;
	logic [7:0]  flags_q;
	logic [31:0] value_q;
	logic [15:0] delta_q;
	logic [31:0] prev_q;

	logic        hb_n;
	logic [7:0]  props_n;
	logic [7:0]  flags_n;
	logic [31:0] value_n;
	logic [15:0] delta_n;
	logic [31:0] prev_n;

	logic [4:0]  pos_w;
	logic [4:0]  s_old;
	logic [4:0]  d0;
	logic [4:0]  q0;
	logic [4:0]  e0;
	logic [2:0]  s_new;
	logic [4:0]  len;
	logic [4:0]  min1;
	logic [4:0]  min2;
	logic        ok;
	logic        prev;

	assign pos_w = {1'b0, pos_q};
	assign s_old = {2'b0, flags_q[2:0]};
	assign d0    = mrd_pkg::HEADER_LEN + s_old;
	assign q0    = d0 + mrd_pkg::DELTA_LEN;
	assign e0    = q0 + s_old;

	always_comb begin
		hb_n    = hb_q;
		props_n = props_q;
		flags_n = flags_q;
		value_n = value_q;
		delta_n = delta_q;
		prev_n  = prev_q;
		unique case (pos_q)
			4'd0: begin
				if (byte_in != class_id) hb_n = 1'b1;
			end
			4'd1: begin
				if (byte_in != report_id) hb_n = 1'b1;
			end
			4'd2: begin
				props_n = byte_in;
			end
			4'd3: begin
				flags_n = byte_in;
			end
			default: begin
				if (mrd_pkg::size_ok(flags_q[2:0])) begin
					if (pos_w < d0) begin
						value_n = {value_q[23:0], byte_in};
					end else if (pos_w < q0) begin
						delta_n = {delta_q[7:0], byte_in};
					end else if (pos_w < e0) begin
						prev_n = {prev_q[23:0], byte_in};
					end
				end
			end
		endcase
	end

	assign s_new = flags_n[2:0];
	assign len   = pos_w + 5'd1;
	assign min1  = mrd_pkg::HEADER_LEN + mrd_pkg::DELTA_LEN + {2'b0, s_new};
	assign min2  = min1 + {2'b0, s_new};
	assign prev  = delta_n != 16'd0;
	assign ok    = (len >= mrd_pkg::HEADER_LEN) && !hb_n &&
		mrd_pkg::size_ok(s_new) && (len >= min1) && (!prev || (len >= min2));

	always_comb begin
		res = '0;
		if (ok) begin
			res.ok               = 1'b1;
			res.meter_type       = props_n[4:0];
			res.rate_type        = props_n[6:5];
			res.scale            = {props_n[7], flags_n[4:3]};
			res.precision        = flags_n[7:5];
			res.value_bytes      = s_new;
			res.reading          = mrd_pkg::sign_extend(value_n, s_new);
			res.delta_time       = delta_n;
			res.has_previous     = prev;
			res.previous_reading = prev ? mrd_pkg::sign_extend(prev_n, s_new) : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hb_q    <= 1'b0;
			props_q <= '0;
			flags_q <= '0;
			value_q <= '0;
			delta_q <= '0;
			prev_q  <= '0;
		end else if (step) begin
			if (last_in) begin
				pos_q   <= '0;
				hb_q    <= 1'b0;
				props_q <= '0;
				flags_q <= '0;
				value_q <= '0;
				delta_q <= '0;
				prev_q  <= '0;
			end else begin
				pos_q   <= (pos_q == mrd_pkg::POS_MAX) ? pos_q : pos_q + 4'd1;
				hb_q    <= hb_n;
				props_q <= props_n;
				flags_q <= flags_n;
				value_q <= value_n;
				delta_q <= delta_n;
				prev_q  <= prev_n;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/mrd_out_reg.sv @@
// Result register of the meter report decoder
`default_nettype none

module mrd_out_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire mrd_pkg::result_t res_in,
	input  wire logic       out_stall,
	output logic            out_valid,
	output mrd_pkg::result_t res_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire

@@ sv/meter_report_decoder.sv @@
// Top level of the meter report decoder
// Usage:
//   Input channel: one payload word per accepted item (payload_byte, last_byte),
//   taken at an edge with in_valid high and in_stall low. last_byte marks the
//   final word of a report.
//   Output channel: one result word per report, shown with out_valid and taken
//   at an edge with out_stall low. ok low means rejected, other fields zero.
//   Config channel: cfg_index 0 writes class_id, 1 writes report_id; others
//   are dropped. cfg_ready is always high; write only while the block is idle.
//   Path: a result is registered when its last word leaves the input register.
//   Throughput: one word per cycle unless a held result stalls a last word,
//   set by the input register and the position counter and accumulator update.
//   Reset: clears the valid flags of the input and result registers, the
//   payload state, and restores class_id to 50 and report_id to 2.
//   Stall: a held result blocks only the next last word; other words keep
//   flowing, and in_stall rises once a last word waits in the input register.
`default_nettype none
`include "assert_macros.svh"

module meter_report_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  payload_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             ok,
	output logic [4:0]       meter_type,
	output logic [1:0]       rate_type,
	output logic [2:0]       scale,
	output logic [2:0]       precision,
	output logic [2:0]       value_bytes,
	output logic signed [31:0] reading,
	output logic [15:0]      delta_time,
	output logic             has_previous,
	output logic signed [31:0] previous_reading,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             drain;
	logic             step;
	logic             load;
	logic [7:0]       class_id_q;
	logic [7:0]       report_id_q;
	mrd_pkg::result_t res_c;
	mrd_pkg::result_t res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_id_q  <= mrd_pkg::CLASS_ID_RESET;
			report_id_q <= mrd_pkg::REPORT_ID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == mrd_pkg::CFG_CLASS_ID) begin
				class_id_q <= cfg_data;
			end else if (cfg_index == mrd_pkg::CFG_REPORT_ID) begin
				report_id_q <= cfg_data;
			end
		end
	end

	assign drain = !last_s1 || !out_valid || !out_stall;
	assign step  = valid_s1 && drain;
	assign load  = step && last_s1;

	mrd_in_reg u_in_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.payload_byte (payload_byte),
		.last_byte    (last_byte),
		.drain        (drain),
		.valid_s1     (valid_s1),
		.byte_s1      (byte_s1),
		.last_s1      (last_s1)
	);

	mrd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (byte_s1),
		.last_in   (last_s1),
		.class_id  (class_id_q),
		.report_id (report_id_q),
		.res       (res_c)
	);

	mrd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res_in    (res_c),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign ok               = res_q.ok;
	assign meter_type       = res_q.meter_type;
	assign rate_type        = res_q.rate_type;
	assign scale            = res_q.scale;
	assign precision        = res_q.precision;
	assign value_bytes      = res_q.value_bytes;
	assign reading          = res_q.reading;
	assign delta_time       = res_q.delta_time;
	assign has_previous     = res_q.has_previous;
	assign previous_reading = res_q.previous_reading;

	`ASSERT_CLK(a_reject_zero, out_valid && !ok |-> reading == 32'd0 && delta_time == 16'd0 && previous_reading == 32'd0 && meter_type == 5'd0, "rejected word carries nonzero fields")
	`ASSERT_CLK(a_prev_delta, out_valid && has_previous |-> delta_time != 16'd0, "previous value without delta time")
	`ASSERT_CLK(a_size_code, out_valid && ok |-> value_bytes == 3'd1 || value_bytes == 3'd2 || value_bytes == 3'd4, "accepted word with bad size code")
	`ASSERT_NEVER(a_stall_empty, in_stall && !valid_s1, "input stalled with empty input register")

endmodule

`default_nettype wire

@@ tb/sv/meter_report_decoder_tb.sv @@
// Self-checking testbench for the meter report decoder: byte stream stimulus, predictor, checker
`timescale 1ns / 1ps

module meter_report_decoder_tb;

	localparam int         QUIET_LIMIT      = 2000;
	localparam int         DRAIN_CYCLES     = 8;
	localparam int         PHASE_WORDS      = 250;
	localparam int         PHASE_COUNT      = 5;
	localparam logic [7:0] CFG_FIRST_UNUSED = 8'd2;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} word_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] payload_byte = 8'd0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic ok;
	logic [4:0] meter_type;
	logic [1:0] rate_type;
	logic [2:0] scale;
	logic [2:0] precision;
	logic [2:0] value_bytes;
	logic signed [31:0] reading;
	logic [15:0] delta_time;
	logic has_previous;
	logic signed [31:0] previous_reading;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = 8'd0;
	logic [7:0] cfg_data = 8'd0;

	meter_report_decoder dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.payload_byte     (payload_byte),
		.last_byte        (last_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.ok               (ok),
		.meter_type       (meter_type),
		.rate_type        (rate_type),
		.scale            (scale),
		.precision        (precision),
		.value_bytes      (value_bytes),
		.reading          (reading),
		.delta_time       (delta_time),
		.has_previous     (has_previous),
		.previous_reading (previous_reading),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #5 clk = ~clk;

	word_t            pending_words[$];
	mrd_pkg::result_t reports_due[$];

	// predictor copy of the decoder state and registers
	logic [7:0]  exp_class_id  = mrd_pkg::CLASS_ID_RESET;
	logic [7:0]  exp_report_id = mrd_pkg::REPORT_ID_RESET;
	logic [3:0]  rx_pos        = 4'd0;
	logic        rx_hdr_bad    = 1'b0;
	logic [7:0]  rx_props      = 8'd0;
	logic [7:0]  rx_flags      = 8'd0;
	logic [31:0] rx_value      = 32'd0;
	logic [15:0] rx_delta      = 16'd0;
	logic [31:0] rx_prev       = 32'd0;

	logic [7:0] hdr_class  = mrd_pkg::CLASS_ID_RESET;
	logic [7:0] hdr_report = mrd_pkg::REPORT_ID_RESET;

	logic        word_taken = 1'b0;
	word_t       drive_word;
	int          burst_left = 0;
	int          gap_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	logic [15:0] stall_tick = 16'd0;
	int          quiet_cycles = 0;

	int mismatches = 0;
	int words_queued = 0;
	int phase_words = 0;
	int reports_queued = 0;
	int reports_decoded = 0;
	int reports_rejected = 0;
	int reg_writes = 0;

	function automatic logic width_code_valid(input int s);
		return s == 1 || s == 2 || s == int'(mrd_pkg::SIZE_CODE_WIDE);
	endfunction

	function automatic logic [31:0] widen(input logic [31:0] raw, input int n);
		int sh;
		sh = 32 - 8 * n;
		return $unsigned($signed(raw << sh) >>> sh);
	endfunction

	task automatic decode_word(input logic [7:0] b, input logic fin);
		int p;
		int s;
		int d0;
		int q0;
		int len;
		logic good;
		mrd_pkg::result_t r;
		p = rx_pos;
		s = rx_flags[2:0];
		if (p == 0) begin
			if (b != exp_class_id)
				rx_hdr_bad = 1'b1;
		end else if (p == 1) begin
			if (b != exp_report_id)
				rx_hdr_bad = 1'b1;
		end else if (p == 2) begin
			rx_props = b;
		end else if (p == 3) begin
			rx_flags = b;
		end else if (width_code_valid(s)) begin
			d0 = mrd_pkg::HEADER_LEN + s;
			q0 = d0 + mrd_pkg::DELTA_LEN;
			if (p < d0)
				rx_value = {rx_value[23:0], b};
			else if (p < q0)
				rx_delta = {rx_delta[7:0], b};
			else if (p < q0 + s)
				rx_prev = {rx_prev[23:0], b};
		end
		if (rx_pos != mrd_pkg::POS_MAX)
			rx_pos = rx_pos + 4'd1;
		if (fin) begin
			len = p + 1;
			s = rx_flags[2:0];
			good = len >= mrd_pkg::HEADER_LEN && !rx_hdr_bad && width_code_valid(s) &&
				len >= mrd_pkg::HEADER_LEN + s + mrd_pkg::DELTA_LEN;
			if (good && rx_delta != 16'd0 &&
				len < mrd_pkg::HEADER_LEN + mrd_pkg::DELTA_LEN + 2 * s)
				good = 1'b0;
			r = '0;
			if (good) begin
				r.ok = 1'b1;
				r.meter_type = rx_props[4:0];
				r.rate_type = rx_props[6:5];
				r.scale = {rx_props[7], rx_flags[4:3]};
				r.precision = rx_flags[7:5];
				r.value_bytes = rx_flags[2:0];
				r.reading = widen(rx_value, s);
				r.delta_time = rx_delta;
				r.has_previous = rx_delta != 16'd0;
				r.previous_reading = r.has_previous ? widen(rx_prev, s) : 32'd0;
			end
			reports_due.push_back(r);
			rx_pos = 4'd0;
			rx_hdr_bad = 1'b0;
			rx_props = 8'd0;
			rx_flags = 8'd0;
			rx_value = 32'd0;
			rx_delta = 16'd0;
			rx_prev = 32'd0;
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_report();
		mrd_pkg::result_t want;
		if (reports_due.size() == 0) begin
			$error("result word with no report outstanding");
			mismatches++;
		end else begin
			want = reports_due.pop_front();
			if (want.ok)
				reports_decoded++;
			else
				reports_rejected++;
			compare_field("ok", want.ok, ok);
			compare_field("meter_type", want.meter_type, meter_type);
			compare_field("rate_type", want.rate_type, rate_type);
			compare_field("scale", want.scale, scale);
			compare_field("precision", want.precision, precision);
			compare_field("value_bytes", want.value_bytes, value_bytes);
			compare_field("reading", want.reading, reading);
			compare_field("delta_time", want.delta_time, delta_time);
			compare_field("has_previous", want.has_previous, has_previous);
			compare_field("previous_reading", want.previous_reading, previous_reading);
		end
	endtask

	// monitor: check results, track register writes, predict accepted words
	always @(posedge clk) begin
		word_taken <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_report();
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
					mrd_pkg::CFG_CLASS_ID:  exp_class_id = cfg_data;
					mrd_pkg::CFG_REPORT_ID: exp_report_id = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				decode_word(payload_byte, last_byte);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// driver: bursts of words with random gaps
	always @(negedge clk) begin
		if (!in_valid || word_taken) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				drive_word = pending_words.pop_front();
				in_valid <= 1'b1;
				payload_byte <= drive_word.data;
				last_byte <= drive_word.last;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, mode changes each time the low byte of stall_tick wraps to zero
	always @(negedge clk) begin
		stall_tick <= stall_tick + 16'd1;
		if (stall_tick[7:0] == 8'd0)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= $urandom_range(0, 3) == 0;
			STALL_HEAVY: out_stall <= $urandom_range(0, 3) != 0;
			default:     out_stall <= stall_tick[2:0] < 3'd3;
		endcase
	end

	task automatic push_report(input logic [7:0] hdr0, input logic [7:0] hdr1,
		input logic [7:0] props, input logic [7:0] flags, input logic [31:0] cur,
		input logic [15:0] dt, input logic [31:0] prv, input int len);
		logic [7:0] seq[$];
		int nb;
		int i;
		nb = (flags[2:0] > 3'd4) ? 4 : flags[2:0];
		seq = {hdr0, hdr1, props, flags};
		for (i = nb - 1; i >= 0; i--)
			seq.push_back(cur[8 * i +: 8]);
		seq.push_back(dt[15:8]);
		seq.push_back(dt[7:0]);
		if (dt != 16'd0)
			for (i = nb - 1; i >= 0; i--)
				seq.push_back(prv[8 * i +: 8]);
		while (seq.size() < len)
			seq.push_back(8'($urandom_range(0, 255)));
		for (i = 0; i < len; i++)
			pending_words.push_back('{data: seq[i], last: i == len - 1});
		words_queued += len;
		phase_words += len;
		reports_queued++;
	endtask

	task automatic random_report();
		logic [7:0] hdr0;
		logic [7:0] hdr1;
		logic [2:0] sz;
		logic [15:0] dt;
		int nb;
		int need;
		int len;
		hdr0 = ($urandom_range(0, 19) != 0) ? hdr_class : 8'($urandom_range(0, 255));
		hdr1 = ($urandom_range(0, 19) != 0) ? hdr_report : 8'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0:       sz = 3'($urandom_range(0, 7));
			1, 2, 3: sz = 3'd1;
			4, 5, 6: sz = 3'd2;
			default: sz = mrd_pkg::SIZE_CODE_WIDE;
		endcase
		case ($urandom_range(0, 5))
			0, 1, 2: dt = 16'd0;
			3:       dt = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0001;
			default: dt = 16'($urandom_range(0, 65535));
		endcase
		nb = (sz > 3'd4) ? 4 : sz;
		need = 6 + nb + ((dt != 16'd0) ? nb : 0);
		case ($urandom_range(0, 9))
			0:       len = $urandom_range(1, need - 1);
			1:       len = $urandom_range(need + 1, 20);
			default: len = need;
		endcase
		push_report(hdr0, hdr1, 8'($urandom_range(0, 255)),
			{5'($urandom_range(0, 31)), sz}, $urandom(), dt, $urandom(), len);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic settle();
		@(posedge clk);
		while (pending_words.size() != 0 || in_valid || reports_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [7:0] new_class;
		logic [7:0] new_report;
		int ph;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			phase_words = 0;
			if (ph == 0) begin
				push_report(hdr_class, hdr_report, 8'h00, 8'h00, 32'd0, 16'd0, 32'd0, 1);
				push_report(hdr_class, hdr_report, 8'hFF, {3'b111, 2'b11, 3'd1},
					32'h0000_0080, 16'd0, 32'd0, 7);
				push_report(hdr_class, hdr_report, 8'h00,
					{5'b00000, mrd_pkg::SIZE_CODE_WIDE},
					32'h8000_0000, 16'hFFFF, 32'h7FFF_FFFF, 14);
				push_report(hdr_class, hdr_report, 8'h5A, {5'b10101, 3'd7},
					$urandom(), 16'h0001, $urandom(), 5);
			end else begin
				settle();
				case (ph)
					1: begin
						new_class = 8'd0;
						new_report = 8'd255;
					end
					2: begin
						new_class = 8'd255;
						new_report = 8'd0;
					end
					default: begin
						new_class = 8'($urandom_range(0, 255));
						new_report = 8'($urandom_range(0, 255));
					end
				endcase
				write_reg(8'($urandom_range(CFG_FIRST_UNUSED, 255)), 8'($urandom_range(0, 255)));
				write_reg(mrd_pkg::CFG_REPORT_ID, new_report);
				write_reg(mrd_pkg::CFG_CLASS_ID, new_class);
				@(negedge clk);
				cfg_valid <= 1'b0;
				hdr_class = new_class;
				hdr_report = new_report;
			end
			while (phase_words < PHASE_WORDS)
				random_report();
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d reports in %0d words over %0d register settings",
			reports_queued, words_queued, PHASE_COUNT);
		$display("%0d decoded, %0d rejected, %0d register writes, %0d mismatches",
			reports_decoded, reports_rejected, reg_writes, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/mrd_pkg.sv
sv/mrd_in_reg.sv
sv/mrd_core.sv
sv/mrd_out_reg.sv
sv/meter_report_decoder.sv
tb/sv/meter_report_decoder_tb.sv
